// ===== src/cpt_pkg.sv =====
`timescale 1ns / 1ps
// cpt_pkg: widths, region codes and transfer types for the closest point on triangle block.
// No dependencies; imported by every module under src.
package cpt_pkg;

	localparam int CW        = 32;          // coordinate width
	localparam int EW        = CW + 1;      // difference / edge width
	localparam int PW        = 2 * EW;      // one component product
	localparam int DW        = PW + 1;      // dot product (sum of three)
	localparam int LW        = 34;          // low slice for the split multiply
	localparam int HW        = DW - LW;     // high slice
	localparam int VW        = 2 * DW;      // second-order terms and divider operands
	localparam int RW        = 32;          // ratio width, unsigned Q0.32
	localparam int TW        = CW + 4;      // output sum before saturation
	localparam int DIV_STEPS = RW + 1;      // one quotient bit per step, top bit saturates
	localparam int DIV_LAT   = DIV_STEPS + 1;
	localparam int QDEPTH    = 2;
	localparam int QAW       = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		RG_A  = 3'd0,
		RG_B  = 3'd1,
		RG_C  = 3'd2,
		RG_AB = 3'd3,
		RG_BC = 3'd4,
		RG_CA = 3'd5,
		RG_IN = 3'd6
	} region_t;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic signed [EW-1:0] edge_t;

	typedef struct packed {
		coord_t [2:0] base;
		edge_t  [2:0] e1;
		edge_t  [2:0] e2;
		logic         full1;
		region_t      region;
		logic         degen;
	} side_t;

	typedef struct packed {
		side_t                 side;
		logic signed [VW-1:0] num;
		logic signed [VW-1:0] den;
	} job_t;

endpackage

// ===== src/cpt_front.sv =====
`timescale 1ns / 1ps
// cpt_front: differences, dot products, second-order terms and region classification.
// Depends on cpt_pkg.
module cpt_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  cpt_pkg::coord_t [2:0]   a,
	input  cpt_pkg::coord_t [2:0]   b,
	input  cpt_pkg::coord_t [2:0]   c,
	input  cpt_pkg::coord_t [2:0]   p,
	output logic                    out_valid,
	output cpt_pkg::job_t           job
);
	import cpt_pkg::*;

	localparam int NK   = 6;
	localparam int NP   = 4;
	localparam int CMPW = DW + 2;
	localparam int XI [NP] = '{0, 2, 0, 4};
	localparam int YI [NP] = '{3, 1, 5, 1};

	typedef struct packed {
		coord_t [2:0] a;
		coord_t [2:0] b;
		coord_t [2:0] c;
		edge_t  [2:0] ab;
		edge_t  [2:0] ac;
		edge_t  [2:0] bc;
		edge_t  [2:0] ca;
	} geom_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	geom_t g_s1, g_s2, g_s3, g_s4, g_s5, g_s6;
	edge_t [2:0] ap_s1, bp_s1, cp_s1;
	logic signed [PW-1:0]    pr_s2 [NK][3];
	logic signed [DW-1:0]    d_s3 [NK];
	logic signed [DW-1:0]    d_s4 [NK];
	logic signed [DW-1:0]    d_s5 [NK];
	logic signed [DW-1:0]    d_s6 [NK];
	logic [2*LW-1:0]         ll_s4 [NP];
	logic signed [LW+HW:0]   lh_s4 [NP];
	logic signed [LW+HW:0]   hl_s4 [NP];
	logic signed [2*HW-1:0]  hh_s4 [NP];
	logic signed [VW-1:0]    pp_s5 [NP];
	logic signed [VW-1:0]    vc_s6, vb_s6;

	logic signed [CMPW-1:0] d43, d56, e1, e2, dab, dca, ebc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			g_s1.a[i]  <= a[i];
			g_s1.b[i]  <= b[i];
			g_s1.c[i]  <= c[i];
			g_s1.ab[i] <= {b[i][CW-1], b[i]} - {a[i][CW-1], a[i]};
			g_s1.ac[i] <= {c[i][CW-1], c[i]} - {a[i][CW-1], a[i]};
			g_s1.bc[i] <= {c[i][CW-1], c[i]} - {b[i][CW-1], b[i]};
			g_s1.ca[i] <= {a[i][CW-1], a[i]} - {c[i][CW-1], c[i]};
			ap_s1[i]   <= {p[i][CW-1], p[i]} - {a[i][CW-1], a[i]};
			bp_s1[i]   <= {p[i][CW-1], p[i]} - {b[i][CW-1], b[i]};
			cp_s1[i]   <= {p[i][CW-1], p[i]} - {c[i][CW-1], c[i]};
		end

		g_s2 <= g_s1;
		for (int i = 0; i < 3; i++) begin
			pr_s2[0][i] <= $signed(g_s1.ab[i]) * $signed(ap_s1[i]);
			pr_s2[1][i] <= $signed(g_s1.ac[i]) * $signed(ap_s1[i]);
			pr_s2[2][i] <= $signed(g_s1.ab[i]) * $signed(bp_s1[i]);
			pr_s2[3][i] <= $signed(g_s1.ac[i]) * $signed(bp_s1[i]);
			pr_s2[4][i] <= $signed(g_s1.ab[i]) * $signed(cp_s1[i]);
			pr_s2[5][i] <= $signed(g_s1.ac[i]) * $signed(cp_s1[i]);
		end

		g_s3 <= g_s2;
		for (int k = 0; k < NK; k++)
			d_s3[k] <= pr_s2[k][0] + pr_s2[k][1] + pr_s2[k][2];

		g_s4 <= g_s3;
		d_s4 <= d_s3;
		for (int j = 0; j < NP; j++) begin
			ll_s4[j] <= d_s3[XI[j]][LW-1:0] * d_s3[YI[j]][LW-1:0];
			lh_s4[j] <= $signed({1'b0, d_s3[XI[j]][LW-1:0]}) * $signed(d_s3[YI[j]][DW-1:LW]);
			hl_s4[j] <= $signed(d_s3[XI[j]][DW-1:LW]) * $signed({1'b0, d_s3[YI[j]][LW-1:0]});
			hh_s4[j] <= $signed(d_s3[XI[j]][DW-1:LW]) * $signed(d_s3[YI[j]][DW-1:LW]);
		end

		g_s5 <= g_s4;
		d_s5 <= d_s4;
		for (int j = 0; j < NP; j++)
			pp_s5[j] <= (VW'(hh_s4[j]) << (2 * LW))
				+ ((VW'(lh_s4[j]) + VW'(hl_s4[j])) << LW)
				+ VW'(ll_s4[j]);

		g_s6  <= g_s5;
		d_s6  <= d_s5;
		vc_s6 <= pp_s5[0] - pp_s5[1];
		vb_s6 <= pp_s5[2] - pp_s5[3];
	end

	// d_s6[0..5] hold d1..d6
	always_comb begin
		d43 = CMPW'(d_s6[3]) - CMPW'(d_s6[2]);
		d56 = CMPW'(d_s6[4]) - CMPW'(d_s6[5]);
		e1  = d43;
		e2  = CMPW'(d_s6[0]) - CMPW'(d_s6[1]);
		dab = CMPW'(d_s6[0]) - CMPW'(d_s6[2]);
		dca = CMPW'(d_s6[5]) - CMPW'(d_s6[1]);
		ebc = e1 + e2;

		job.side.base   = g_s6.a;
		job.side.e1     = g_s6.ab;
		job.side.e2     = g_s6.ac;
		job.side.full1  = 1'b0;
		job.side.region = RG_IN;
		job.side.degen  = 1'b0;
		job.num         = '0;
		job.den         = '0;

		if (d_s6[0] <= 0 && d_s6[1] <= 0) begin
			job.side.region = RG_A;
		end else if (d_s6[2] >= 0 && d43 <= 0) begin
			job.side.region = RG_B;
			job.side.base   = g_s6.b;
		end else if (d_s6[5] >= 0 && d56 <= 0) begin
			job.side.region = RG_C;
			job.side.base   = g_s6.c;
		end else if (vc_s6 <= 0 && d_s6[0] >= 0 && d_s6[2] <= 0) begin
			job.side.region = RG_AB;
			job.num         = VW'(d_s6[0]);
			job.den         = VW'(dab);
		end else if (vc_s6 >= 0 && e1 >= 0 && e2 >= 0) begin
			job.side.region = RG_BC;
			job.side.base   = g_s6.b;
			job.side.e1     = g_s6.bc;
			job.num         = VW'(e1);
			job.den         = VW'(ebc);
		end else if (vb_s6 <= 0 && d_s6[5] >= 0 && d_s6[1] <= 0) begin
			job.side.region = RG_CA;
			job.side.base   = g_s6.c;
			job.side.e1     = g_s6.ca;
			job.num         = VW'(d_s6[5]);
			job.den         = VW'(dca);
		end else begin
			// interior: denominator va+vb+vc reduces to vb, so the first ratio saturates
			job.side.region = RG_IN;
			job.side.degen  = (vb_s6 == 0);
			job.side.full1  = (vb_s6 != 0);
			job.num         = vc_s6;
			job.den         = vb_s6;
		end
	end

	assign out_valid = v_s6;

endmodule

// ===== src/cpt_queue.sv =====
`timescale 1ns / 1ps
// cpt_queue: short FIFO between the classifying front and the divide/scale back.
// Depends on cpt_pkg.
module cpt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cpt_pkg::job_t  wdata,
	input  logic           pop,
	output cpt_pkg::job_t  rdata,
	output logic           empty,
	output logic           full
);
	import cpt_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;
	logic           do_push, do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (QAW+1)'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == QAW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == QAW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

endmodule

// ===== src/cpt_div.sv =====
`timescale 1ns / 1ps
// cpt_div: pipelined restoring divider giving floor(num * 2^32 / den) as unsigned Q0.32.
// Saturates at all ones, returns zero for zero or opposite-sign operands. Depends on cpt_pkg.
module cpt_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic signed [cpt_pkg::VW-1:0] num,
	input  logic signed [cpt_pkg::VW-1:0] den,
	output logic                  out_valid,
	output logic [cpt_pkg::RW-1:0] ratio
);
	import cpt_pkg::*;

	localparam int RMW = VW + 1;

	logic                    v_s   [DIV_STEPS+1];
	logic [RMW-1:0]          rem_s [DIV_STEPS+1];
	logic [VW-1:0]           den_s [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]    q_s   [DIV_STEPS+1];
	logic                    kill_s [DIV_STEPS+1];

	logic          neg, kill;
	logic [VW-1:0] an, ad;

	always_comb begin
		neg  = num[VW-1];
		kill = (den == '0) || (num == '0) || (num[VW-1] != den[VW-1]);
		an   = neg ? VW'(-num) : VW'(num);
		ad   = neg ? VW'(-den) : VW'(den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else
			v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= {1'b0, an};
		den_s[0]  <= ad;
		q_s[0]    <= '0;
		kill_s[0] <= kill;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [RMW-1:0] tr;
		logic [RMW:0]   df;
		logic           ge;

		assign tr = (k == 0) ? rem_s[k] : {rem_s[k][RMW-2:0], 1'b0};
		assign df = {1'b0, tr} - {2'b00, den_s[k]};
		assign ge = !df[RMW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[k+1] <= 1'b0;
			else
				v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? df[RMW-1:0] : tr;
			den_s[k+1]  <= den_s[k];
			q_s[k+1]    <= {q_s[k][DIV_STEPS-2:0], ge};
			kill_s[k+1] <= kill_s[k];
		end
	end

	assign out_valid = v_s[DIV_STEPS];
	assign ratio = kill_s[DIV_STEPS]          ? '0 :
		q_s[DIV_STEPS][DIV_STEPS-1]          ? '1 : q_s[DIV_STEPS][RW-1:0];

endmodule

// ===== src/cpt_back.sv =====
`timescale 1ns / 1ps
// cpt_back: divides, scales the chosen edges by the ratios and adds them to the base vertex.
// Depends on cpt_pkg and cpt_div.
module cpt_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  cpt_pkg::job_t          job,
	output logic                   done,
	output cpt_pkg::coord_t [2:0]  q,
	output cpt_pkg::region_t       region,
	output logic                   degenerate
);
	import cpt_pkg::*;

	localparam int MW = RW + EW + 1;

	logic          dv;
	logic [RW-1:0] rv, r1, r2;
	side_t         side_s [DIV_LAT];
	side_t         sd;

	logic                 v_s1, v_s2;
	logic signed [MW-1:0] t1_s1 [3];
	logic signed [MW-1:0] t2_s1 [3];
	coord_t [2:0]         base_s1;
	region_t              region_s1, region_s2;
	logic                 degen_s1, degen_s2;
	coord_t [2:0]         q_s2;
	logic signed [TW-1:0] sum [3];

	cpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.num       (job.num),
		.den       (job.den),
		.out_valid (dv),
		.ratio     (rv)
	);

	always_ff @(posedge clk) begin
		side_s[0] <= job.side;
		for (int k = 1; k < DIV_LAT; k++)
			side_s[k] <= side_s[k-1];
	end

	assign sd = side_s[DIV_LAT-1];

	always_comb begin
		r1 = sd.full1 ? '1 : ((sd.region == RG_IN) ? '0 : rv);
		r2 = (sd.region == RG_IN) ? rv : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= dv;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			t1_s1[i] <= $signed({1'b0, r1}) * $signed(sd.e1[i]);
			t2_s1[i] <= $signed({1'b0, r2}) * $signed(sd.e2[i]);
		end
		base_s1   <= sd.base;
		region_s1 <= sd.region;
		degen_s1  <= sd.degen;
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			sum[i] = TW'($signed(base_s1[i])) + TW'(t1_s1[i] >>> RW) + TW'(t2_s1[i] >>> RW);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (sum[i][TW-1:CW-1] == '0 || sum[i][TW-1:CW-1] == '1)
				q_s2[i] <= sum[i][CW-1:0];
			else if (sum[i][TW-1])
				q_s2[i] <= {1'b1, {(CW-1){1'b0}}};
			else
				q_s2[i] <= {1'b0, {(CW-1){1'b1}}};
		end
		region_s2 <= region_s1;
		degen_s2  <= degen_s1;
	end

	assign done       = v_s2;
	assign q          = q_s2;
	assign region     = region_s2;
	assign degenerate = degen_s2;

endmodule

// ===== src/closest_point_on_triangle.sv =====
`timescale 1ns / 1ps
// closest_point_on_triangle: top level, front classifier, queue and divide/scale back end.
// Depends on cpt_pkg, cpt_front, cpt_queue, cpt_back.
//
// Usage:
//   Drive A, B, C and P (signed Q16.16) and raise start; the transfer is taken at
//   the rising edge where start is high and busy is low. One triangle/point pair
//   can be taken every cycle.
//   Each result (qx, qy, qz, region, degenerate) is shown for exactly one cycle
//   with done high, in input order.
//   Items pass the six-stage dot product front (split 67x67 products), the queue,
//   the 34-stage divider (an input register, then quotient bit stages) and two scale stages.
//   Throughput is one item per cycle; busy only rises if the queue between the
//   front and back fills, which does not happen since the back drains it every cycle.
//   The receiver cannot stall; done is not held.
//   Reset (arst_n low, asynchronous) clears all valid flags and the queue; items in
//   flight are dropped and no result appears until new inputs are transferred.
module closest_point_on_triangle (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [31:0]      ax,
	input  logic signed [31:0]      ay,
	input  logic signed [31:0]      az,
	input  logic signed [31:0]      bx,
	input  logic signed [31:0]      by,
	input  logic signed [31:0]      bz,
	input  logic signed [31:0]      cx,
	input  logic signed [31:0]      cy,
	input  logic signed [31:0]      cz,
	input  logic signed [31:0]      px,
	input  logic signed [31:0]      py,
	input  logic signed [31:0]      pz,
	output logic                    done,
	output logic signed [31:0]      qx,
	output logic signed [31:0]      qy,
	output logic signed [31:0]      qz,
	output logic [2:0]              region,
	output logic                    degenerate
);
	import cpt_pkg::*;

	coord_t [2:0] a, b, c, p, q;
	logic         f_valid, q_empty, q_full;
	job_t         f_job, q_job;
	region_t      b_region;

	assign a = {az, ay, ax};
	assign b = {bz, by, bx};
	assign c = {cz, cy, cx};
	assign p = {pz, py, px};

	cpt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.a         (a),
		.b         (b),
		.c         (c),
		.p         (p),
		.out_valid (f_valid),
		.job       (f_job)
	);

	cpt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_valid),
		.wdata  (f_job),
		.pop    (!q_empty),
		.rdata  (q_job),
		.empty  (q_empty),
		.full   (q_full)
	);

	cpt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.job        (q_job),
		.done       (done),
		.q          (q),
		.region     (b_region),
		.degenerate (degenerate)
	);

	assign busy   = q_full;
	assign qx     = q[0];
	assign qy     = q[1];
	assign qz     = q[2];
	assign region = b_region;

endmodule

// ===== tb/cpt_checker.sv =====
`timescale 1ns / 1ps
// cpt_checker: watches input and result transfers of closest_point_on_triangle, predicts
// the closest point and region with wide exact arithmetic, and counts mismatches.
// Depends on cpt_pkg.
module cpt_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  cpt_pkg::coord_t ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz,
	input  logic            done,
	input  cpt_pkg::coord_t qx, qy, qz,
	input  logic [2:0]      region,
	input  logic            degenerate,
	output int              fails,
	output int              pending
);
	import cpt_pkg::*;

	typedef logic signed [199:0] wide_t;

	typedef struct {
		coord_t  q [3];
		region_t rg;
		logic    degen;
	} point_t;

	point_t closest_q[$];

	function automatic logic [31:0] frac_ratio(wide_t num, wide_t den);
		logic [239:0] nu, du, qu;
		if (den == 0 || num == 0 || ((num < 0) != (den < 0)))
			return 32'd0;
		if (num < 0) begin
			num = -num;
			den = -den;
		end
		nu = num;
		du = den;
		qu = (nu << 32) / du;
		if (qu > 240'hFFFF_FFFF)
			return 32'hFFFF_FFFF;
		return qu[31:0];
	endfunction

	function automatic wide_t scale_edge(logic [31:0] r, wide_t e);
		wide_t t;
		t = $signed({168'b0, r}) * e;
		return t >>> 32;
	endfunction

	function automatic coord_t clamp_coord(wide_t v);
		if (v > 2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic wide_t dot(wide_t u [3], wide_t v [3]);
		return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
	endfunction

	function automatic point_t closest_point(coord_t in [12]);
		wide_t a [3], b [3], c [3], p [3], ab [3], ac [3], ap [3], bp [3], cp [3], q [3];
		wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, e1, e2, den;
		logic [31:0] r, v, w;
		point_t res;
		for (int i = 0; i < 3; i++) begin
			a[i] = in[i];
			b[i] = in[3 + i];
			c[i] = in[6 + i];
			p[i] = in[9 + i];
			ab[i] = b[i] - a[i];
			ac[i] = c[i] - a[i];
			ap[i] = p[i] - a[i];
			bp[i] = p[i] - b[i];
			cp[i] = p[i] - c[i];
		end
		d1 = dot(ab, ap); d2 = dot(ac, ap);
		d3 = dot(ab, bp); d4 = dot(ac, bp);
		d5 = dot(ab, cp); d6 = dot(ac, cp);
		vc = d1 * d4 - d3 * d2;
		va = d3 * d2 - d1 * d4;
		vb = d1 * d6 - d5 * d2;
		e1 = d4 - d3;
		e2 = d1 - d2;
		res.degen = 1'b0;
		if (d1 <= 0 && d2 <= 0) begin
			res.rg = RG_A;
			q = a;
		end else if (d3 >= 0 && d4 - d3 <= 0) begin
			res.rg = RG_B;
			q = b;
		end else if (d6 >= 0 && d5 - d6 <= 0) begin
			res.rg = RG_C;
			q = c;
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			res.rg = RG_AB;
			r = frac_ratio(d1, d1 - d3);
			for (int i = 0; i < 3; i++)
				q[i] = a[i] + scale_edge(r, ab[i]);
		end else if (va <= 0 && e1 >= 0 && e2 >= 0) begin
			res.rg = RG_BC;
			r = frac_ratio(e1, e1 + e2);
			for (int i = 0; i < 3; i++)
				q[i] = b[i] + scale_edge(r, c[i] - b[i]);
		end else if (vb <= 0 && d6 >= 0 && d2 <= 0) begin
			res.rg = RG_CA;
			r = frac_ratio(d6, d6 - d2);
			for (int i = 0; i < 3; i++)
				q[i] = c[i] + scale_edge(r, a[i] - c[i]);
		end else begin
			res.rg = RG_IN;
			den = va + vb + vc;
			if (den == 0) begin
				res.degen = 1'b1;
				q = a;
			end else begin
				v = frac_ratio(vb, den);
				w = frac_ratio(vc, den);
				for (int i = 0; i < 3; i++)
					q[i] = a[i] + scale_edge(v, ab[i]) + scale_edge(w, ac[i]);
			end
		end
		for (int i = 0; i < 3; i++)
			res.q[i] = clamp_coord(q[i]);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_t exp_pt;
		coord_t got [3];
		string  nm [3];
		int     nerr;
		nerr = 0;
		if (!arst_n) begin
			fails   <= 0;
			pending <= 0;
			closest_q.delete();
		end else begin
			if (done) begin
				if (closest_q.size() == 0) begin
					$error("result transfer with nothing outstanding");
					nerr++;
				end else begin
					exp_pt = closest_q.pop_front();
					got = '{qx, qy, qz};
					nm = '{"qx", "qy", "qz"};
					for (int i = 0; i < 3; i++)
						if (got[i] !== exp_pt.q[i]) begin
							$error("%s expected %0d got %0d", nm[i], exp_pt.q[i], got[i]);
							nerr++;
						end
					if (region !== exp_pt.rg) begin
						$error("region expected %0d got %0d", exp_pt.rg, region);
						nerr++;
					end
					if (degenerate !== exp_pt.degen) begin
						$error("degenerate expected %0d got %0d", exp_pt.degen, degenerate);
						nerr++;
					end
				end
			end
			if (start && !busy)
				closest_q.push_back(closest_point('{ax, ay, az, bx, by, bz,
					cx, cy, cz, px, py, pz}));
			fails   <= fails + nerr;
			pending <= closest_q.size();
		end
	end
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for closest_point_on_triangle; directed triangles, then
// random ones with idle bursts. Depends on cpt_pkg, cpt_checker and the block under src.
module tb_top;
	import cpt_pkg::*;

	typedef coord_t item_t [12];

	localparam coord_t ONE  = 32'sh0001_0000;
	localparam coord_t HALF = 32'sh0000_8000;
	localparam coord_t CMAX = 32'sh7FFF_FFFF;
	localparam coord_t CMIN = 32'sh8000_0000;
	localparam int     N_RANDOM = 1630;
	localparam int     STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, degenerate;
	logic [2:0] region;
	coord_t ax = '0, ay = '0, az = '0, bx = '0, by = '0, bz = '0;
	coord_t cx = '0, cy = '0, cz = '0, px = '0, py = '0, pz = '0;
	coord_t qx, qy, qz;
	int fails, pending, stall_cnt = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	closest_point_on_triangle DUT (.*);
	cpt_checker u_checker (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic coord_t rnd_span(int bits);
		logic [31:0] r;
		r = $urandom;
		return $signed(r) >>> (32 - bits);
	endfunction

	task automatic send(item_t it, bit hold_off);
		ax <= it[0]; ay <= it[1]; az <= it[2];
		bx <= it[3]; by <= it[4]; bz <= it[5];
		cx <= it[6]; cy <= it[7]; cz <= it[8];
		px <= it[9]; py <= it[10]; pz <= it[11];
		start <= 1'b1;
		@(posedge clk iff !busy);
		if (hold_off && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	function automatic item_t random_tri();
		item_t it;
		int bits, k;
		case ($urandom_range(0, 9))
			0, 1: for (int i = 0; i < 12; i++) it[i] = $urandom;
			9: begin
				// collinear or coincident vertices
				bits = $urandom_range(4, 24);
				for (int i = 0; i < 12; i++) it[i] = rnd_span(bits);
				k = $urandom_range(0, 3);
				for (int i = 0; i < 3; i++) begin
					if (k == 0) it[3 + i] = it[i];
					it[6 + i] = it[i] + k * (it[3 + i] - it[i]);
				end
			end
			default: begin
				bits = $urandom_range(2, 30);
				for (int i = 0; i < 12; i++) it[i] = rnd_span(bits);
				if ($urandom_range(0, 2) == 0)
					for (int i = 0; i < 3; i++) it[9 + i] = it[i] + rnd_span(bits - 1);
			end
		endcase
		return it;
	endfunction

	initial begin
		item_t dir [$];
		dir.push_back('{default: 32'sd0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2 * ONE, -HALF, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -HALF, 2 * ONE, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, HALF, -ONE, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, HALF, 0});
		dir.push_back('{0, 0, 0, ONE, 0, 0, 0, ONE, 0, HALF / 2, HALF / 2, ONE});
		dir.push_back('{0, 0, 0, 0, 0, 0, ONE, 0, 0, HALF, ONE, 0});
		dir.push_back('{0, 0, 0, ONE, ONE, 0, 2 * ONE, 2 * ONE, 0, ONE, 0, ONE});
		dir.push_back('{default: CMAX});
		dir.push_back('{default: CMIN});
		dir.push_back('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 0, 0, CMAX});
		dir.push_back('{CMAX, CMAX, 0, CMIN, CMAX, 0, CMAX, CMIN, 0, 0, 0, CMIN});
		dir.push_back('{CMIN, 0, CMAX, CMAX, 0, CMIN, 0, CMAX, 0, CMAX, CMIN, CMAX});
		dir.push_back('{CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, 1, 1, -1});
		dir.push_back('{CMIN, CMIN, 0, CMAX, CMIN, 0, CMIN, CMAX, 0, CMAX, CMAX, 0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[i])
			send(dir[i], 1'b0);
		for (int n = 0; n < N_RANDOM; n++) begin
			if (n == N_RANDOM / 2) begin
				start <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send(random_tri(), n < N_RANDOM - 200);
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
